@@ rtl/tes_pkg.sv @@
// tes_pkg: shared types and character constants for the terminal escape stripper
// no dependencies; used by tes_class, terminal_escape_stripper, tes_checker and the testbench
`default_nettype none
package tes_pkg;

   localparam int CHAR_W = 16;

   localparam logic [CHAR_W-1:0] CH_TAB     = 16'h0009;
   localparam logic [CHAR_W-1:0] CH_LF      = 16'h000A;
   localparam logic [CHAR_W-1:0] CH_CR      = 16'h000D;
   localparam logic [CHAR_W-1:0] CH_ESC     = 16'h001B;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 16'h0020;
   localparam logic [CHAR_W-1:0] CH_FINAL_LO = 16'h0040;
   localparam logic [CHAR_W-1:0] CH_BRACKET = 16'h005B;
   localparam logic [CHAR_W-1:0] CH_FINAL_HI = 16'h007E;
   localparam logic [CHAR_W-1:0] CH_DEL     = 16'h007F;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [CHAR_W-1:0] ch;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              has_char;
      logic              last;
      logic              whitespace_dropped;
   } rsp_type;

   typedef struct packed {
      logic is_esc;
      logic is_bracket;
      logic is_final;
      logic is_drop;
      logic is_lf;
      logic is_cr;
      logic is_space;
   } class_type;

endpackage
`default_nettype wire

@@ rtl/tes_ram.sv @@
// tes_ram: generic single-write, single-read synchronous RAM with registered read
// no dependencies
`default_nettype none
module tes_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ rtl/tes_class.sv @@
// tes_class: classifies one 16-bit character for the stripper control logic
// depends on tes_pkg
`default_nettype none
module tes_class (
   input  wire logic [tes_pkg::CHAR_W-1:0] ch,
   output tes_pkg::class_type              cls
);

   logic ascii_ws;
   logic uni_ws;

   always_comb begin
      ascii_ws = (ch >= tes_pkg::CH_TAB && ch <= tes_pkg::CH_CR) ||
                 ch == tes_pkg::CH_SPACE || ch == 16'h0085 || ch == 16'h00A0;
      uni_ws   = ch == 16'h1680 || (ch >= 16'h2000 && ch <= 16'h200A) ||
                 ch == 16'h2028 || ch == 16'h2029 || ch == 16'h202F ||
                 ch == 16'h205F || ch == 16'h3000;
      cls.is_esc     = ch == tes_pkg::CH_ESC;
      cls.is_bracket = ch == tes_pkg::CH_BRACKET;
      cls.is_final   = ch >= tes_pkg::CH_FINAL_LO && ch <= tes_pkg::CH_FINAL_HI;
      cls.is_drop    = (ch < tes_pkg::CH_SPACE && ch != tes_pkg::CH_LF &&
                        ch != tes_pkg::CH_CR && ch != tes_pkg::CH_TAB) ||
                       ch == tes_pkg::CH_DEL;
      cls.is_lf      = ch == tes_pkg::CH_LF;
      cls.is_cr      = ch == tes_pkg::CH_CR;
      cls.is_space   = ascii_ws || uni_ws;
   end

endmodule
`default_nettype wire

@@ rtl/terminal_escape_stripper.sv @@
// terminal_escape_stripper: top level, escape/control filter with held-whitespace RAM
// depends on tes_pkg, tes_class, tes_ram
//
// Usage:
//   req channel carries one character (kind 0) or an end marker (kind 1).
//   rsp channel carries cleaned characters and, for each end marker, one
//   terminator with last set and whitespace_dropped reporting hold overflow.
//   A request is taken when req_valid is high and req_stall is low; results
//   move the same way on rsp_valid / rsp_stall.
//   A plain result is loaded into the rsp register in the cycle after its
//   request is taken; with entries held, the held whitespace is read from
//   the RAM and passed out first, then the character itself.
//   Throughput: one request per cycle while nothing is held and the rsp
//   register is not stalled. Trailing whitespace sits in a HOLD_DEPTH-entry
//   RAM; a non-whitespace character arriving with N entries held is
//   followed by a flush of N RAM reads, and req_stall stays high until
//   that character is out. req_stall also rises whenever the rsp
//   register is full and stalled. Reset clears the parser state, the hold
//   count and the rsp valid flag; the RAM contents need no clearing. An end
//   marker clears the parser state and the hold count the same way.
`default_nettype none
module terminal_escape_stripper #(
   parameter int HOLD_DEPTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tes_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output tes_pkg::rsp_type      rsp_data
);

   localparam int IW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
   localparam int CW = $clog2(HOLD_DEPTH + 1);

   typedef enum logic [1:0] {ST_RUN, ST_FLUSH, ST_CHAR} state_type;

   state_type                  state_ff, state_in;
   logic                       in_escape_ff, in_escape_in;
   logic                       in_csi_ff, in_csi_in;
   logic                       cr_pending_ff, cr_pending_in;
   logic [1:0]                 newline_run_ff, newline_run_in;
   logic                       seen_content_ff, seen_content_in;
   logic [CW-1:0]              held_count_ff, held_count_in;
   logic                       overflow_ff, overflow_in;
   logic [IW-1:0]              idx_ff, idx_in;
   logic [tes_pkg::CHAR_W-1:0] pend_ff, pend_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   tes_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   tes_pkg::class_type         cls;
   logic                       accept;
   logic                       out_free;
   logic                       wr_en;
   logic [IW-1:0]              rd_addr;
   logic [tes_pkg::CHAR_W-1:0] rd_data;
   logic [tes_pkg::CHAR_W-1:0] c_eff;

   tes_class u_class (
      .ch  (req_data.ch),
      .cls (cls)
   );

   tes_ram #(
      .WIDTH (tes_pkg::CHAR_W),
      .DEPTH (HOLD_DEPTH)
   ) u_hold (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (held_count_ff[IW-1:0]),
      .wr_data (c_eff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_RUN) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign c_eff     = cls.is_cr ? tes_pkg::CH_LF : req_data.ch;

   always_comb begin
      state_in        = state_ff;
      in_escape_in    = in_escape_ff;
      in_csi_in       = in_csi_ff;
      cr_pending_in   = cr_pending_ff;
      newline_run_in  = newline_run_ff;
      seen_content_in = seen_content_ff;
      held_count_in   = held_count_ff;
      overflow_in     = overflow_ff;
      idx_in          = idx_ff;
      pend_in         = pend_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;
      wr_en           = 1'b0;
      rd_addr         = idx_ff;

      case (state_ff)
         ST_RUN: begin
            if (accept) begin
               if (req_data.kind == tes_pkg::KIND_END) begin
                  rsp_valid_in                   = 1'b1;
                  rsp_data_in.out_char           = '0;
                  rsp_data_in.has_char           = 1'b0;
                  rsp_data_in.last               = 1'b1;
                  rsp_data_in.whitespace_dropped = overflow_ff;
                  in_escape_in    = 1'b0;
                  in_csi_in       = 1'b0;
                  cr_pending_in   = 1'b0;
                  newline_run_in  = '0;
                  seen_content_in = 1'b0;
                  held_count_in   = '0;
                  overflow_in     = 1'b0;
               end else if (in_escape_ff) begin
                  if (cls.is_bracket) begin
                     in_csi_in = 1'b1;
                  end else if (cls.is_final) begin
                     in_escape_in = 1'b0;
                     in_csi_in    = 1'b0;
                  end
               end else if (cls.is_esc) begin
                  in_escape_in = 1'b1;
               end else if (cls.is_drop) begin
                  in_escape_in = in_escape_ff;
               end else if (cls.is_lf && cr_pending_ff) begin
                  cr_pending_in = 1'b0;
               end else begin
                  cr_pending_in = cls.is_cr;
                  if ((cls.is_lf || cls.is_cr) && newline_run_ff >= 2'd2) begin
                     newline_run_in = newline_run_ff;
                  end else begin
                     if (cls.is_lf || cls.is_cr) begin
                        newline_run_in = newline_run_ff + 2'd1;
                     end else begin
                        newline_run_in = '0;
                     end
                     if (cls.is_space) begin
                        if (seen_content_ff) begin
                           if (held_count_ff < CW'(HOLD_DEPTH)) begin
                              wr_en         = 1'b1;
                              held_count_in = held_count_ff + CW'(1);
                           end else begin
                              overflow_in = 1'b1;
                           end
                        end
                     end else begin
                        seen_content_in = 1'b1;
                        if (held_count_ff != '0) begin
                           pend_in  = req_data.ch;
                           idx_in   = '0;
                           rd_addr  = '0;
                           state_in = ST_FLUSH;
                        end else begin
                           rsp_valid_in                   = 1'b1;
                           rsp_data_in.out_char           = req_data.ch;
                           rsp_data_in.has_char           = 1'b1;
                           rsp_data_in.last               = 1'b0;
                           rsp_data_in.whitespace_dropped = 1'b0;
                        end
                     end
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.out_char           = rd_data;
               rsp_data_in.has_char           = 1'b1;
               rsp_data_in.last               = 1'b0;
               rsp_data_in.whitespace_dropped = 1'b0;
               idx_in  = idx_ff + IW'(1);
               rd_addr = idx_ff + IW'(1);
               if (CW'(idx_ff) + CW'(1) == held_count_ff) begin
                  held_count_in = '0;
                  state_in      = ST_CHAR;
               end
            end
         end
         ST_CHAR: begin
            if (out_free) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.out_char           = pend_ff;
               rsp_data_in.has_char           = 1'b1;
               rsp_data_in.last               = 1'b0;
               rsp_data_in.whitespace_dropped = 1'b0;
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_RUN;
         in_escape_ff    <= 1'b0;
         in_csi_ff       <= 1'b0;
         cr_pending_ff   <= 1'b0;
         newline_run_ff  <= '0;
         seen_content_ff <= 1'b0;
         held_count_ff   <= '0;
         overflow_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         in_escape_ff    <= in_escape_in;
         in_csi_ff       <= in_csi_in;
         cr_pending_ff   <= cr_pending_in;
         newline_run_ff  <= newline_run_in;
         seen_content_ff <= seen_content_in;
         held_count_ff   <= held_count_in;
         overflow_ff     <= overflow_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   // flush only runs with something held
   a_flush_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH |-> held_count_ff != '0)
      else $error("flush with empty hold buffer");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= CW'(HOLD_DEPTH))
      else $error("hold count beyond depth");

   // end marker leaves clean state
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.kind == tes_pkg::KIND_END |=>
         held_count_ff == '0 && !overflow_ff && !seen_content_ff && rsp_valid_ff &&
         rsp_data_ff.last)
      else $error("end marker did not clear state");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_RUN |-> !accept)
      else $error("request taken during flush");

endmodule
`default_nettype wire

@@ verif/tes_checker.sv @@
// tes_checker: watches both channels of terminal_escape_stripper, predicts the
// cleaned stream and compares every result; depends on tes_pkg only
`timescale 1ns / 100ps
module tes_checker
   import tes_pkg::*;
#(
   parameter int HOLD_DEPTH = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_data,
   output int           mismatch_count,
   output int           awaited,
   output int           strings_closed,
   output int           chars_passed,
   output int           overflow_flags
);

   logic              esc_open;
   logic              csi_open;
   logic              cr_seen;
   logic [1:0]        lf_run;
   logic              content_seen;
   logic [CHAR_W-1:0] held_ws [HOLD_DEPTH];
   int                held_count;
   logic              ws_lost;
   rsp_type           cleaned_q [$];
   int                errs = 0;
   int                n_strings = 0;
   int                n_chars = 0;
   int                n_overflow = 0;

   function automatic logic is_blank(input logic [CHAR_W-1:0] c);
      return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE || c == 16'h0085
         || c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A)
         || c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F
         || c == 16'h3000;
   endfunction

   task automatic clear_state();
      esc_open = 1'b0;
      csi_open = 1'b0;
      cr_seen = 1'b0;
      lf_run = 2'd0;
      content_seen = 1'b0;
      held_count = 0;
      ws_lost = 1'b0;
   endtask

   task automatic push_char(input logic [CHAR_W-1:0] c);
      rsp_type res;
      res = '0;
      res.out_char = c;
      res.has_char = 1'b1;
      cleaned_q.push_back(res);
   endtask

   task automatic clean_request(input req_type r);
      logic [CHAR_W-1:0] c;
      rsp_type           res;
      int                i;
      c = r.ch;
      if (r.kind == KIND_END) begin
         res = '0;
         res.last = 1'b1;
         res.whitespace_dropped = ws_lost;
         cleaned_q.push_back(res);
         clear_state();
         return;
      end
      if (esc_open) begin
         if (c == CH_BRACKET) begin
            csi_open = 1'b1;
         end else if (c >= CH_FINAL_LO && c <= CH_FINAL_HI) begin
            esc_open = 1'b0;
            csi_open = 1'b0;
         end
         return;
      end
      if (c == CH_ESC) begin
         esc_open = 1'b1;
         return;
      end
      if ((c < CH_SPACE && c != CH_LF && c != CH_CR && c != CH_TAB) || c == CH_DEL)
         return;
      if (c == CH_LF && cr_seen) begin
         cr_seen = 1'b0;
         return;
      end
      if (c == CH_CR) begin
         cr_seen = 1'b1;
         c = CH_LF;
      end else begin
         cr_seen = 1'b0;
      end
      if (c == CH_LF) begin
         if (lf_run == 2'd2)
            return;
         lf_run = lf_run + 2'd1;
      end else begin
         lf_run = 2'd0;
      end
      if (is_blank(c)) begin
         if (!content_seen)
            return;
         if (held_count < HOLD_DEPTH) begin
            held_ws[held_count] = c;
            held_count++;
         end else begin
            ws_lost = 1'b1;
         end
         return;
      end
      for (i = 0; i < held_count; i++)
         push_char(held_ws[i]);
      held_count = 0;
      push_char(c);
      content_seen = 1'b1;
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type exp;
      if (cleaned_q.size() == 0) begin
         errs++;
         $display("%0t: unexpected result %h, nothing pending", $time, got);
         return;
      end
      exp = cleaned_q.pop_front();
      if (got.out_char !== exp.out_char) begin
         errs++;
         $display("%0t: out_char expected %h actual %h", $time, exp.out_char, got.out_char);
      end
      if (got.has_char !== exp.has_char) begin
         errs++;
         $display("%0t: has_char expected %b actual %b", $time, exp.has_char, got.has_char);
      end
      if (got.last !== exp.last) begin
         errs++;
         $display("%0t: last expected %b actual %b", $time, exp.last, got.last);
      end
      if (got.whitespace_dropped !== exp.whitespace_dropped) begin
         errs++;
         $display("%0t: whitespace_dropped expected %b actual %b", $time,
                  exp.whitespace_dropped, got.whitespace_dropped);
      end
      if (got.has_char === 1'b1)
         n_chars++;
      if (got.last === 1'b1)
         n_strings++;
      if (got.whitespace_dropped === 1'b1)
         n_overflow++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         cleaned_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_result(rsp_data);
         if (req_valid && !req_stall)
            clean_request(req_data);
      end
      mismatch_count <= errs;
      awaited <= cleaned_q.size();
      strings_closed <= n_strings;
      chars_passed <= n_chars;
      overflow_flags <= n_overflow;
   end

endmodule

@@ verif/tb_terminal_escape_stripper.sv @@
// tb_terminal_escape_stripper: drives directed and random terminal text with
// random idling into terminal_escape_stripper; depends on tes_pkg, tes_checker
`timescale 1ns / 100ps
module tb_terminal_escape_stripper;
   import tes_pkg::*;

   localparam int HOLD_DEPTH = 32;
   localparam int BODY_ITEMS = 300;
   localparam int IDLE_LIMIT = 5000;
   localparam int SQUEEZE_CYCLES = 300;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int   mismatch_count;
   int   awaited;
   int   strings_closed;
   int   chars_passed;
   int   overflow_flags;
   int   req_total = 0;
   logic sender_calm = 1'b0;
   logic squeeze_go = 1'b0;

   logic [CHAR_W-1:0] intro [23] = '{
      CH_SPACE, 16'h3000, 16'h0041, CH_ESC, CH_ESC, CH_BRACKET, CH_BRACKET,
      16'h0031, 16'h006D, CH_ESC, 16'h0030, CH_FINAL_HI, CH_CR, 16'h0001,
      CH_LF, CH_LF, CH_LF, CH_LF, CH_DEL, 16'hFFFF, CH_TAB, 16'h0000, 16'h005A
   };

   logic [CHAR_W-1:0] blank_set [12] = '{
      CH_TAB, CH_SPACE, 16'h0085, 16'h00A0, 16'h1680, 16'h2000, 16'h200A,
      16'h2028, 16'h2029, 16'h202F, 16'h205F, 16'h3000
   };

   always #2 clock = ~clock;

   terminal_escape_stripper #(.HOLD_DEPTH(HOLD_DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   tes_checker #(.HOLD_DEPTH(HOLD_DEPTH)) u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .awaited        (awaited),
      .strings_closed (strings_closed),
      .chars_passed   (chars_passed),
      .overflow_flags (overflow_flags)
   );

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_item(input logic k, input logic [CHAR_W-1:0] c);
      int      gap;
      req_type r;
      gap = sender_calm ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.kind = k;
      r.ch = c;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_total++;
   endtask

   task automatic send_text();
      int n;
      int r;
      n = $urandom_range(1, 6);
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 70)
            send_item(KIND_CHAR, CHAR_W'($urandom_range(16'h21, 16'h7E)));
         else if (r < 90)
            send_item(KIND_CHAR, CHAR_W'($urandom_range(16'h80, 16'hFFFF)));
         else
            send_item(KIND_CHAR, CHAR_W'($urandom));
      end
   endtask

   task automatic send_blanks();
      int n;
      if ($urandom_range(0, 99) < 12)
         n = $urandom_range(HOLD_DEPTH - 2, HOLD_DEPTH + 6);
      else
         n = $urandom_range(1, 5);
      repeat (n) begin
         send_item(KIND_CHAR, blank_set[$urandom_range(0, 11)]);
      end
   endtask

   task automatic send_breaks();
      int n;
      int r;
      n = $urandom_range(1, 4);
      repeat (n) begin
         r = $urandom_range(0, 2);
         if (r != 1)
            send_item(KIND_CHAR, CH_CR);
         if (r != 0)
            send_item(KIND_CHAR, CH_LF);
      end
   endtask

   task automatic send_escape();
      int n;
      int r;
      send_item(KIND_CHAR, CH_ESC);
      r = $urandom_range(0, 99);
      if (r < 55) begin
         send_item(KIND_CHAR, CH_BRACKET);
         n = $urandom_range(0, 4);
         repeat (n) begin
            if ($urandom_range(0, 9) == 0)
               send_item(KIND_CHAR, CH_BRACKET);
            else
               send_item(KIND_CHAR, CHAR_W'($urandom_range(16'h30, 16'h3F)));
         end
      end else if (r < 70) begin
         send_item(KIND_CHAR, CHAR_W'($urandom_range(16'h20, 16'h3F)));
      end else if (r < 75) begin
         send_item(KIND_CHAR, CH_ESC);
      end
      if ($urandom_range(0, 9) != 0)
         send_item(KIND_CHAR, CHAR_W'($urandom_range(CH_FINAL_LO, CH_FINAL_HI)));
   endtask

   task automatic send_noise();
      int r;
      r = $urandom_range(0, 2);
      if (r == 0)
         send_item(KIND_CHAR, CHAR_W'($urandom_range(0, 16'h1F)));
      else if (r == 1)
         send_item(KIND_CHAR, CH_DEL);
      else
         send_item(KIND_CHAR, CHAR_W'($urandom));
   endtask

   initial begin
      int i;
      int segs;
      int r;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_item(KIND_END, 16'h0000);
      for (i = 0; i < 23; i++)
         send_item(KIND_CHAR, intro[i]);
      send_item(KIND_END, 16'hFFFF);

      while (req_total < BODY_ITEMS) begin
         if (!squeeze_go && req_total >= 100)
            squeeze_go <= 1'b1;
         sender_calm = ($urandom_range(0, 3) == 0);
         segs = $urandom_range(1, 8);
         repeat (segs) begin
            r = $urandom_range(0, 99);
            if (r < 35)
               send_text();
            else if (r < 55)
               send_blanks();
            else if (r < 70)
               send_breaks();
            else if (r < 90)
               send_escape();
            else
               send_noise();
         end
         send_item(KIND_END, CHAR_W'($urandom));
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("run covered %0d requests in %0d strings, %0d characters passed,",
               req_total, strings_closed, chars_passed);
      $display("%0d strings reported held whitespace overflow", overflow_flags);
      if (mismatch_count == 0 && awaited == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int  n;
      logic squeezed;
      squeezed = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (squeeze_go && !squeezed) begin
            squeezed = 1'b1;
            rsp_stall <= 1'b1;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
         end
         n = idle_len();
         if ($urandom_range(0, 99) < 3) begin
            rsp_stall <= 1'b0;
            repeat (40) @(posedge clock);
         end else if (n == 0) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("%0t: no traffic for %0d cycles", $time, IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

endmodule
